FILE: src/obb_pkg.sv
package obb_pkg;

	localparam int unsigned EPS_LSB     = 16;
	localparam int unsigned ROUND_HALF  = 8192;
	localparam int unsigned MQ_DEPTH    = 2;
	localparam int unsigned MQ_PTR_W    = $clog2(MQ_DEPTH);
	localparam int unsigned MQ_CNT_W    = $clog2(MQ_DEPTH + 1);
	localparam int unsigned BACK_STAGES = 7;
	localparam int unsigned OQ_DEPTH    = 16;
	localparam int unsigned OQ_PTR_W    = $clog2(OQ_DEPTH);
	localparam int unsigned OQ_CNT_W    = $clog2(OQ_DEPTH + 1);

	// one box pair after unpacking: centre difference, axes, clamped half extents
	typedef struct packed {
		logic [2:0][16:0]      d;
		logic [2:0][2:0][15:0] a;
		logic [2:0][2:0][15:0] b;
		logic [2:0][14:0]      ha;
		logic [2:0][14:0]      hb;
	} obb_item_t;

	typedef struct packed {
		logic [OQ_CNT_W-1:0] ocnt;
		logic [OQ_CNT_W-1:0] inflight;
	} obb_stat_t;

	// cyclic successor of an axis index
	function automatic int unsigned nxt(input int unsigned i);
		return (i == 2) ? 0 : i + 1;
	endfunction

endpackage

FILE: src/obb_obb_overlap_test_unit.sv
// OBB-OBB overlap test over the fifteen separating axes. One box pair is
// accepted per cycle and gives one overlap flag; results leave in order. An
// item is unpacked and written into a two-entry queue at the edge it is
// accepted, and the seven-stage arithmetic pipeline picks it up from there
// and writes its flag into the result queue that drives the output. The
// pipeline only takes a pair while the sixteen-entry result queue has room
// for everything in flight, so a stalled consumer backs up into full
// without losing items; with pop held high the rate is one item per cycle.
module obb_obb_overlap_test_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [47:0] box_a_center,
	input  logic [47:0] box_a_axis_u,
	input  logic [47:0] box_a_axis_v,
	input  logic [47:0] box_a_axis_w,
	input  logic [47:0] box_a_half_size,
	input  logic [47:0] box_b_center,
	input  logic [47:0] box_b_axis_u,
	input  logic [47:0] box_b_axis_v,
	input  logic [47:0] box_b_axis_w,
	input  logic [47:0] box_b_half_size,
	output logic        empty,
	input  logic        pop,
	output logic        boxes_overlap
);

	obb_pkg::obb_item_t front_item, mid_item;
	obb_pkg::obb_stat_t back_stat;
	logic               mid_valid, mid_pop;

	obb_front u_front (
		.box_a_center    (box_a_center),
		.box_a_axis_u    (box_a_axis_u),
		.box_a_axis_v    (box_a_axis_v),
		.box_a_axis_w    (box_a_axis_w),
		.box_a_half_size (box_a_half_size),
		.box_b_center    (box_b_center),
		.box_b_axis_u    (box_b_axis_u),
		.box_b_axis_v    (box_b_axis_v),
		.box_b_axis_w    (box_b_axis_w),
		.box_b_half_size (box_b_half_size),
		.item            (front_item)
	);

	obb_mid_q u_mid_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (push),
		.wr_item  (front_item),
		.full     (full),
		.rd_en    (mid_pop),
		.rd_valid (mid_valid),
		.rd_item  (mid_item)
	);

	obb_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (mid_valid),
		.item          (mid_item),
		.item_pop      (mid_pop),
		.pop           (pop),
		.empty         (empty),
		.boxes_overlap (boxes_overlap),
		.stat          (back_stat)
	);

	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		(({1'b0, back_stat.ocnt} + {1'b0, back_stat.inflight})
			<= (obb_pkg::OQ_CNT_W + 1)'(obb_pkg::OQ_DEPTH)))
		else $error("result queue over-committed");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> mid_valid)
		else $error("accepted item missing from mid queue");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> mid_valid)
		else $error("back end took from an empty mid queue");

endmodule

FILE: src/obb_front.sv
module obb_front (
	input  logic [47:0]        box_a_center,
	input  logic [47:0]        box_a_axis_u,
	input  logic [47:0]        box_a_axis_v,
	input  logic [47:0]        box_a_axis_w,
	input  logic [47:0]        box_a_half_size,
	input  logic [47:0]        box_b_center,
	input  logic [47:0]        box_b_axis_u,
	input  logic [47:0]        box_b_axis_v,
	input  logic [47:0]        box_b_axis_w,
	input  logic [47:0]        box_b_half_size,
	output obb_pkg::obb_item_t item
);

	always_comb begin
		logic [15:0] ca, cb, hsa, hsb;
		for (int k = 0; k < 3; k++) begin
			ca  = box_a_center[16*k +: 16];
			cb  = box_b_center[16*k +: 16];
			hsa = box_a_half_size[16*k +: 16];
			hsb = box_b_half_size[16*k +: 16];
			item.d[k] = 17'($signed(cb)) - 17'($signed(ca));
			item.a[0][k] = box_a_axis_u[16*k +: 16];
			item.a[1][k] = box_a_axis_v[16*k +: 16];
			item.a[2][k] = box_a_axis_w[16*k +: 16];
			item.b[0][k] = box_b_axis_u[16*k +: 16];
			item.b[1][k] = box_b_axis_v[16*k +: 16];
			item.b[2][k] = box_b_axis_w[16*k +: 16];
			// negative half extent counts as zero
			item.ha[k] = hsa[15] ? 15'd0 : hsa[14:0];
			item.hb[k] = hsb[15] ? 15'd0 : hsb[14:0];
		end
	end

endmodule

FILE: src/obb_mid_q.sv
module obb_mid_q (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  obb_pkg::obb_item_t wr_item,
	output logic               full,
	input  logic               rd_en,
	output logic               rd_valid,
	output obb_pkg::obb_item_t rd_item
);

	obb_pkg::obb_item_t                 mem_q [obb_pkg::MQ_DEPTH];
	logic [obb_pkg::MQ_PTR_W-1:0]       wp_q, rp_q;
	logic [obb_pkg::MQ_CNT_W-1:0]       cnt_q;
	logic                               do_wr, do_rd;

	assign full     = (cnt_q == obb_pkg::MQ_CNT_W'(obb_pkg::MQ_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;
	assign rd_item  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == obb_pkg::MQ_PTR_W'(obb_pkg::MQ_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == obb_pkg::MQ_PTR_W'(obb_pkg::MQ_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + obb_pkg::MQ_CNT_W'(do_wr) - obb_pkg::MQ_CNT_W'(do_rd);
		end
	end

endmodule

FILE: src/obb_back.sv
module obb_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  obb_pkg::obb_item_t item,
	output logic               item_pop,
	input  logic               pop,
	output logic               empty,
	output logic               boxes_overlap,
	output obb_pkg::obb_stat_t stat
);

	localparam int unsigned BS = obb_pkg::BACK_STAGES;
	localparam int unsigned CW = obb_pkg::OQ_CNT_W;

	logic [BS-1:0] v_q;

	logic signed [32:0] tp_s1 [3][3];
	logic signed [31:0] sp_s1 [3][3][3];
	logic [14:0]        ha_s1 [3], hb_s1 [3];

	logic signed [34:0] t_s2 [3];
	logic signed [33:0] s_s2 [3][3];
	logic [14:0]        ha_s2 [3], hb_s2 [3];

	logic signed [18:0] r_c [3][3];
	logic [18:0]        e_c [3][3];
	logic signed [34:0] t_s3 [3];
	logic signed [18:0] r_s3 [3][3];
	logic [18:0]        e_s3 [3][3];
	logic [14:0]        ha_s3 [3], hb_s3 [3];

	logic signed [37:0] ql_s4 [3][3][3];
	logic signed [35:0] qh_s4 [3][3][3];
	logic [33:0]        pa_s4 [3][3][3];
	logic [33:0]        pb_s4 [3][3][3];
	logic signed [34:0] t_s4 [3];
	logic [14:0]        ha_s4 [3], hb_s4 [3];

	logic signed [55:0] q_s5 [3][3][3];
	logic [36:0]        rad_a_s5 [3];
	logic [35:0]        rad_b_s5 [3];
	logic [35:0]        rad_c_s5 [3][3];
	logic signed [34:0] t_s5 [3];
	logic [14:0]        hb_s5 [3];

	logic [59:0]        lhs_c [15], rhs_c [15];
	logic [59:0]        lhs_s6 [15], rhs_s6 [15];
	logic [14:0]        sep_c;
	logic               ov_s7;

	logic               oq_q [obb_pkg::OQ_DEPTH];
	logic [obb_pkg::OQ_PTR_W-1:0] owp_q, orp_q;
	logic [CW-1:0]      ocnt_q;
	logic [CW-1:0]      inflight;
	logic [CW:0]        credit_sum;
	logic               opush, opop;

	// issue only while the output queue has room for everything in flight
	assign inflight   = CW'($countones(v_q));
	assign credit_sum = (CW + 1)'(ocnt_q) + (CW + 1)'(inflight);
	assign item_pop   = item_valid && (credit_sum < (CW + 1)'(obb_pkg::OQ_DEPTH));
	assign opush      = v_q[BS-1];
	assign empty      = (ocnt_q == '0);
	assign opop       = pop && !empty;
	assign boxes_overlap = oq_q[orp_q];
	assign stat.ocnt     = ocnt_q;
	assign stat.inflight = inflight;

	// products for t and the rotation matrix
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ha_s1[i] <= item.ha[i];
			hb_s1[i] <= item.hb[i];
			for (int k = 0; k < 3; k++) begin
				tp_s1[i][k] <= $signed(item.d[k]) * $signed(item.a[i][k]);
			end
			for (int j = 0; j < 3; j++) begin
				for (int k = 0; k < 3; k++) begin
					sp_s1[i][j][k] <= $signed(item.a[i][k]) * $signed(item.b[j][k]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ha_s2[i] <= ha_s1[i];
			hb_s2[i] <= hb_s1[i];
			t_s2[i]  <= 35'(tp_s1[i][0]) + 35'(tp_s1[i][1]) + 35'(tp_s1[i][2]);
			for (int j = 0; j < 3; j++) begin
				s_s2[i][j] <= 34'(sp_s1[i][j][0]) + 34'(sp_s1[i][j][1])
					+ 34'(sp_s1[i][j][2]);
			end
		end
	end

	// Q28 -> Q14, half away from zero; epsilon margin
	always_comb begin
		logic [33:0] sabs, rnd;
		logic [17:0] m;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				sabs = s_s2[i][j][33] ? 34'(-s_s2[i][j]) : 34'(s_s2[i][j]);
				rnd  = sabs + 34'(obb_pkg::ROUND_HALF);
				m    = rnd[31:14];
				r_c[i][j] = s_s2[i][j][33] ? -$signed({1'b0, m}) : $signed({1'b0, m});
				e_c[i][j] = {1'b0, m} + 19'(obb_pkg::EPS_LSB);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ha_s3[i] <= ha_s2[i];
			hb_s3[i] <= hb_s2[i];
			t_s3[i]  <= t_s2[i];
			for (int j = 0; j < 3; j++) begin
				r_s3[i][j] <= r_c[i][j];
				e_s3[i][j] <= e_c[i][j];
			end
		end
	end

	// t * r split into low and high halves of t; radius products
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			ha_s4[k] <= ha_s3[k];
			hb_s4[k] <= hb_s3[k];
			t_s4[k]  <= t_s3[k];
			for (int m = 0; m < 3; m++) begin
				for (int j = 0; j < 3; j++) begin
					ql_s4[k][m][j] <= $signed({1'b0, t_s3[k][17:0]}) * r_s3[m][j];
					qh_s4[k][m][j] <= $signed(t_s3[k][34:18]) * r_s3[m][j];
					pa_s4[k][m][j] <= ha_s3[k] * e_s3[m][j];
					pb_s4[k][m][j] <= hb_s3[k] * e_s3[m][j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		int unsigned i1, i2, j1, j2;
		for (int k = 0; k < 3; k++) begin
			t_s5[k]  <= t_s4[k];
			hb_s5[k] <= hb_s4[k];
			for (int m = 0; m < 3; m++) begin
				for (int j = 0; j < 3; j++) begin
					q_s5[k][m][j] <= $signed({{2{qh_s4[k][m][j][35]}}, qh_s4[k][m][j], 18'd0})
						+ $signed({{18{ql_s4[k][m][j][37]}}, ql_s4[k][m][j]});
				end
			end
		end
		for (int i = 0; i < 3; i++) begin
			rad_a_s5[i] <= 37'({ha_s4[i], 14'd0}) + 37'(pb_s4[0][i][0])
				+ 37'(pb_s4[1][i][1]) + 37'(pb_s4[2][i][2]);
			rad_b_s5[i] <= 36'(pa_s4[0][0][i]) + 36'(pa_s4[1][1][i]) + 36'(pa_s4[2][2][i]);
		end
		for (int i = 0; i < 3; i++) begin
			i1 = obb_pkg::nxt(i);
			i2 = obb_pkg::nxt(i1);
			for (int j = 0; j < 3; j++) begin
				j1 = obb_pkg::nxt(j);
				j2 = obb_pkg::nxt(j1);
				rad_c_s5[i][j] <= 36'(pa_s4[i1][i2][j]) + 36'(pa_s4[i2][i1][j])
					+ 36'(pb_s4[j1][i][j2]) + 36'(pb_s4[j2][i][j1]);
			end
		end
	end

	// projected distance and radii for all fifteen axes
	always_comb begin
		logic [34:0]        tabs;
		logic signed [57:0] sb;
		logic [57:0]        sb_abs;
		logic signed [56:0] dc;
		logic [56:0]        dc_abs;
		int unsigned        i1, i2;
		for (int i = 0; i < 3; i++) begin
			tabs = t_s5[i][34] ? 35'(-t_s5[i]) : 35'(t_s5[i]);
			lhs_c[i] = 60'(tabs);
			rhs_c[i] = 60'(rad_a_s5[i]);
		end
		for (int j = 0; j < 3; j++) begin
			sb = 58'(q_s5[0][0][j]) + 58'(q_s5[1][1][j]) + 58'(q_s5[2][2][j]);
			sb_abs = sb[57] ? 58'(-sb) : 58'(sb);
			lhs_c[3 + j] = 60'(sb_abs);
			rhs_c[3 + j] = 60'({rad_b_s5[j], 14'd0}) + 60'({hb_s5[j], 28'd0});
		end
		for (int i = 0; i < 3; i++) begin
			i1 = obb_pkg::nxt(i);
			i2 = obb_pkg::nxt(i1);
			for (int j = 0; j < 3; j++) begin
				dc = 57'(q_s5[i2][i1][j]) - 57'(q_s5[i1][i2][j]);
				dc_abs = dc[56] ? 57'(-dc) : 57'(dc);
				lhs_c[6 + 3*i + j] = 60'(dc_abs);
				rhs_c[6 + 3*i + j] = 60'({rad_c_s5[i][j], 14'd0});
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int x = 0; x < 15; x++) begin
			lhs_s6[x] <= lhs_c[x];
			rhs_s6[x] <= rhs_c[x];
		end
	end

	// touching counts as overlap: strict compare
	always_comb begin
		for (int x = 0; x < 15; x++) begin
			sep_c[x] = lhs_s6[x] > rhs_s6[x];
		end
	end

	always_ff @(posedge clk) begin
		ov_s7 <= ~|sep_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[BS-2:0], item_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (opush) begin
			oq_q[owp_q] <= ov_s7;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q  <= '0;
			orp_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (opush) begin
				owp_q <= (owp_q == obb_pkg::OQ_PTR_W'(obb_pkg::OQ_DEPTH - 1)) ? '0 : owp_q + 1'b1;
			end
			if (opop) begin
				orp_q <= (orp_q == obb_pkg::OQ_PTR_W'(obb_pkg::OQ_DEPTH - 1)) ? '0 : orp_q + 1'b1;
			end
			ocnt_q <= ocnt_q + CW'(opush) - CW'(opop);
		end
	end

endmodule
